>>> sv/cgd_pkg.sv
// Package for the cell-grid difference decoder: parse phases, result kinds,
// status codes, register indexes and the result item struct. No dependencies.
package cgd_pkg;

  localparam int unsigned MaxCharsPerCell = 4;
  localparam int unsigned CharCntW = $clog2(MaxCharsPerCell + 1);
  localparam logic [31:0] FrameMagic = 32'h4b4d5831;
  localparam logic [20:0] CodepointMax = 21'h10ffff;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  typedef enum logic [4:0] {
    PH_MAGIC, PH_ROWS, PH_COLS, PH_CROW, PH_CCOL, PH_FLAGS, PH_CHANGED, PH_ROW,
    PH_RUNS, PH_RCOL, PH_RLEN, PH_ATTRS, PH_UL, PH_WID, PH_FG, PH_BG, PH_CHARS,
    PH_CP
  } phase_e;

  typedef enum logic [2:0] {
    KIND_SIZE  = 3'd0,
    KIND_CELL  = 3'd1,
    KIND_CP    = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_PROTOCOL  = 2'd2
  } status_e;

  localparam logic [7:0] RegMaxDim = 8'd0;
  localparam logic [7:0] RegMaxKind = 8'd1;

  typedef struct packed {
    logic        message_done;
    logic [1:0]  status;
    logic        cursor_shown;
    logic [20:0] char_value;
    logic [31:0] bg_color;
    logic [31:0] fg_color;
    logic [7:0]  glyph_width;
    logic [7:0]  underline;
    logic [15:0] attrs;
    logic [15:0] col;
    logic [15:0] row;
    logic [2:0]  kind;
  } result_t;

  // Front to queue: up to two results per byte.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } pair_t;

endpackage

>>> sv/cgd_front.sv
// Front end of the decoder: varint gathering, field parsing and bounds checks.
// One byte per cycle while step_i is high, up to two results. Depends on cgd_pkg.
module cgd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic [15:0]     max_dim_i,
  input  logic [7:0]      max_kind_i,
  output cgd_pkg::pair_t  pair_o
);
  import cgd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  bcnt_q, bcnt_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [15:0] rows_q, rows_d, cols_q, cols_d;
  logic [63:0] crow_q, crow_d, ccol_q, ccol_d;
  logic [15:0] rows_left_q, rows_left_d, runs_left_q, runs_left_d;
  logic [15:0] cells_left_q, cells_left_d;
  logic [CharCntW-1:0] chars_left_q, chars_left_d;
  logic [15:0] cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [15:0] attrs_q, attrs_d;
  logic [7:0]  ul_q, ul_d, wid_q, wid_d;
  logic [31:0] fg_q, fg_d, bg_q, bg_d;
  logic        vis_q, vis_d;
  logic        failed_q, failed_d;

  logic        is_var, have, done;
  logic [1:0]  err;
  logic [63:0] v;
  logic [63:0] part;
  logic [31:0] col_shift;
  logic [16:0] col_room;
  logic [15:0] col_next;
  result_t     r0, r1, rz;
  logic        e0;
  logic        restart;

  always_comb begin
    is_var = (phase_q inside {[PH_ROWS:PH_CCOL], [PH_CHANGED:PH_ATTRS], PH_CHARS, PH_CP});
    part = 64'(byte_i[6:0]) << shift_q[5:0];
    col_shift = {fg_q[23:0], byte_i};
    col_room = 17'(cols_q) - 17'(cur_col_q);
    col_next = cur_col_q + 16'd1;
  end

  always_comb begin
    phase_d = phase_q; bcnt_d = bcnt_q; acc_d = acc_q; shift_d = shift_q;
    rows_d = rows_q; cols_d = cols_q; crow_d = crow_q; ccol_d = ccol_q;
    rows_left_d = rows_left_q; runs_left_d = runs_left_q;
    cells_left_d = cells_left_q; chars_left_d = chars_left_q;
    cur_row_d = cur_row_q; cur_col_d = cur_col_q; attrs_d = attrs_q;
    ul_d = ul_q; wid_d = wid_q; fg_d = fg_q; bg_d = bg_q; vis_d = vis_q;
    failed_d = failed_q;
    have = 1'b1; done = 1'b0; err = ST_OK; v = '0;
    rz = '0; r0 = '0; r1 = '0; e0 = 1'b0; restart = 1'b0;

    if (failed_q) begin
      have = 1'b0;
      if (last_i) begin
        failed_d = 1'b0; restart = 1'b1;
      end
    end else if (is_var) begin
      if (shift_q > 7'd63) begin
        err = ST_PROTOCOL;
      end else if (byte_i[7]) begin
        acc_d = acc_q | part; shift_d = shift_q + 7'd7; have = 1'b0;
      end else begin
        v = acc_q | part; acc_d = '0; shift_d = '0;
      end
    end

    if (!failed_q && err == ST_OK && have) begin
      case (phase_q)
        PH_MAGIC: begin
          acc_d = {32'd0, acc_q[23:0], byte_i};
          if (bcnt_q == 2'd3) begin
            bcnt_d = '0;
            if (acc_d[31:0] != FrameMagic) err = ST_PROTOCOL;
            else begin
              acc_d = '0; phase_d = PH_ROWS;
            end
          end else bcnt_d = bcnt_q + 2'd1;
        end
        PH_ROWS: begin
          if (v > 64'(max_dim_i)) err = ST_PROTOCOL;
          else begin
            rows_d = v[15:0]; phase_d = PH_COLS;
          end
        end
        PH_COLS: begin
          if (v > 64'(max_dim_i) || v == '0 || rows_q == '0) err = ST_PROTOCOL;
          else begin
            cols_d = v[15:0]; phase_d = PH_CROW;
          end
        end
        PH_CROW: begin
          crow_d = v; phase_d = PH_CCOL;
        end
        PH_CCOL: begin
          ccol_d = v; phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          vis_d = byte_i[0];
          if (crow_q >= 64'(rows_q) || ccol_q >= 64'(cols_q)) err = ST_PROTOCOL;
          else begin
            e0 = 1'b1;
            r0.kind = KIND_SIZE; r0.row = rows_q; r0.col = cols_q;
            phase_d = PH_CHANGED;
          end
        end
        PH_CHANGED: begin
          if (v > 64'(rows_q)) err = ST_PROTOCOL;
          else begin
            rows_left_d = v[15:0];
            if (v == '0) done = 1'b1;
            else phase_d = PH_ROW;
          end
        end
        PH_ROW: begin
          if (v >= 64'(rows_q)) err = ST_PROTOCOL;
          else begin
            cur_row_d = v[15:0]; rows_left_d = rows_left_q - 16'd1; phase_d = PH_RUNS;
          end
        end
        PH_RUNS: begin
          if (v > 64'(cols_q)) err = ST_PROTOCOL;
          else begin
            runs_left_d = v[15:0];
            if (v != '0) phase_d = PH_RCOL;
            else if (rows_left_q != '0) phase_d = PH_ROW;
            else done = 1'b1;
          end
        end
        PH_RCOL: begin
          if (v >= 64'(cols_q)) err = ST_PROTOCOL;
          else begin
            cur_col_d = v[15:0]; runs_left_d = runs_left_q - 16'd1; phase_d = PH_RLEN;
          end
        end
        PH_RLEN: begin
          if (v > 64'(col_room)) err = ST_PROTOCOL;
          else begin
            cells_left_d = v[15:0]; phase_d = PH_ATTRS;
          end
        end
        PH_ATTRS: begin
          if (v > 64'hffff) err = ST_PROTOCOL;
          else begin
            attrs_d = v[15:0]; phase_d = PH_UL;
          end
        end
        PH_UL: begin
          ul_d = byte_i; phase_d = PH_WID;
        end
        PH_WID: begin
          wid_d = byte_i; bcnt_d = '0; phase_d = PH_FG;
        end
        PH_FG: begin
          fg_d = col_shift;
          if (bcnt_q == 2'd3) begin
            bcnt_d = '0;
            if (col_shift[31:24] > max_kind_i) err = ST_PROTOCOL;
            else phase_d = PH_BG;
          end else bcnt_d = bcnt_q + 2'd1;
        end
        PH_BG: begin
          bg_d = {bg_q[23:0], byte_i};
          if (bcnt_q == 2'd3) begin
            bcnt_d = '0;
            if (bg_d[31:24] > max_kind_i || cells_left_q == '0) err = ST_PROTOCOL;
            else phase_d = PH_CHARS;
          end else bcnt_d = bcnt_q + 2'd1;
        end
        PH_CHARS: begin
          if (v > 64'(MaxCharsPerCell)) err = ST_PROTOCOL;
          else begin
            cells_left_d = cells_left_q - 16'd1;
            e0 = 1'b1;
            r0.kind = KIND_CELL; r0.row = cur_row_q; r0.col = cur_col_q;
            r0.attrs = attrs_q; r0.underline = ul_q; r0.glyph_width = wid_q;
            r0.fg_color = fg_q; r0.bg_color = bg_q; r0.char_value = v[20:0];
            chars_left_d = v[CharCntW-1:0];
            if (v == '0) begin
              cur_col_d = col_next;
              if (cells_left_d != '0) phase_d = PH_CHARS;
              else if (runs_left_q != '0) phase_d = PH_RCOL;
              else if (rows_left_q != '0) phase_d = PH_ROW;
              else done = 1'b1;
            end else phase_d = PH_CP;
          end
        end
        PH_CP: begin
          if (v > 64'(CodepointMax)) err = ST_PROTOCOL;
          else begin
            e0 = 1'b1;
            r0.kind = KIND_CP; r0.row = cur_row_q; r0.col = cur_col_q;
            r0.char_value = v[20:0];
            chars_left_d = chars_left_q - CharCntW'(1);
            if (chars_left_d == '0) begin
              cur_col_d = col_next;
              if (cells_left_q != '0) phase_d = PH_CHARS;
              else if (runs_left_q != '0) phase_d = PH_RCOL;
              else if (rows_left_q != '0) phase_d = PH_ROW;
              else done = 1'b1;
            end
          end
        end
        default: err = ST_PROTOCOL;
      endcase
    end

    if (!failed_q) begin
      r1 = rz;
      if (err != ST_OK) begin
        r1.kind = KIND_ERROR; r1.status = err; r1.message_done = 1'b1;
        restart = 1'b1;
        if (!last_i) failed_d = 1'b1;
      end else if (done) begin
        if (last_i) begin
          r1.kind = KIND_END; r1.row = crow_q[15:0]; r1.col = ccol_q[15:0];
          r1.cursor_shown = vis_d; r1.message_done = 1'b1;
        end else begin
          r1.kind = KIND_ERROR; r1.status = ST_PROTOCOL; r1.message_done = 1'b1;
          failed_d = 1'b1;
        end
        restart = 1'b1;
      end else if (last_i) begin
        r1.kind = KIND_ERROR; r1.status = ST_TRUNCATED; r1.message_done = 1'b1;
        restart = 1'b1;
      end
    end

    if (restart) begin
      phase_d = PH_MAGIC; bcnt_d = '0; acc_d = '0; shift_d = '0;
      rows_d = '0; cols_d = '0; crow_d = '0; ccol_d = '0;
      rows_left_d = '0; runs_left_d = '0; cells_left_d = '0; chars_left_d = '0;
      cur_row_d = '0; cur_col_d = '0; attrs_d = '0; ul_d = '0; wid_d = '0;
      fg_d = '0; bg_d = '0; vis_d = 1'b0;
    end

    // Pack: cell/size/cp result first, then the closing result if any.
    pair_o.res0 = e0 ? r0 : r1;
    pair_o.res1 = r1;
    pair_o.valid0 = step_i && (e0 || (!failed_q && (restart || err != ST_OK)));
    pair_o.valid1 = step_i && e0 && !failed_q && restart;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC; bcnt_q <= '0; acc_q <= '0; shift_q <= '0;
      rows_q <= '0; cols_q <= '0; crow_q <= '0; ccol_q <= '0;
      rows_left_q <= '0; runs_left_q <= '0; cells_left_q <= '0; chars_left_q <= '0;
      cur_row_q <= '0; cur_col_q <= '0; attrs_q <= '0; ul_q <= '0; wid_q <= '0;
      fg_q <= '0; bg_q <= '0; vis_q <= 1'b0; failed_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; bcnt_q <= bcnt_d; acc_q <= acc_d; shift_q <= shift_d;
      rows_q <= rows_d; cols_q <= cols_d; crow_q <= crow_d; ccol_q <= ccol_d;
      rows_left_q <= rows_left_d; runs_left_q <= runs_left_d;
      cells_left_q <= cells_left_d; chars_left_q <= chars_left_d;
      cur_row_q <= cur_row_d; cur_col_q <= cur_col_d; attrs_q <= attrs_d;
      ul_q <= ul_d; wid_q <= wid_d; fg_q <= fg_d; bg_q <= bg_d; vis_q <= vis_d;
      failed_q <= failed_d;
    end
  end

endmodule

>>> sv/cgd_queue.sv
// Result queue between parser and output: takes up to two items per cycle,
// gives one while ready_i is high. Depends on cgd_pkg.
module cgd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cgd_pkg::pair_t   pair_i,
  output logic             room2_o,
  output logic             valid_o,
  input  logic             ready_i,
  output cgd_pkg::result_t res_o
);
  import cgd_pkg::*;

  result_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic pop;
  logic [QueuePtrW:0] nin;

  always_comb begin
    pop = valid_o && ready_i;
    nin = (QueuePtrW + 1)'(pair_i.valid0) + (QueuePtrW + 1)'(pair_i.valid1);
    wr_d = wr_q + QueuePtrW'(nin);
    rd_d = rd_q + QueuePtrW'(pop);
    cnt_d = cnt_q + nin - (QueuePtrW + 1)'(pop);
    valid_o = cnt_q != '0;
    res_o = mem_q[rd_q];
    room2_o = cnt_q <= (QueuePtrW + 1)'(QueueDepth - 2);
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.valid0) mem_q[wr_q] <= pair_i.res0;
    if (pair_i.valid1) mem_q[wr_q + QueuePtrW'(1)] <= pair_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/cell_grid_diff_decoder.sv
// Top level of the cell-grid difference decoder: config registers, parser
// front end and result queue. Depends on cgd_pkg, cgd_front, cgd_queue.
//
//  channel | direction | handshake             | payload
//  s_axis  | in        | s_axis_tvalid/tready  | tdata byte_value, tlast last
//  m_axis  | out       | m_axis_tvalid/tready  | tdata fields (see port), tuser kind,
//          |           |                       | tlast message_done
//  cfg     | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while the queue has room; each byte yields
// zero, one or two results, which enter a four-entry queue. Input stalls only
// when the queue has fewer than two free entries. Results pass through the
// queue registers before they appear on m_axis. Reset clears parser state and
// empties the queue; max_dimension returns to 4096 and max_color_kind to 2.
module cell_grid_diff_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // byte_value
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row[15:0], col[31:16], attrs[47:32], underline[55:48], glyph_width[63:56],
  // fg_color[95:64], bg_color[127:96], char_value[148:128], cursor_shown[149],
  // status[151:150]
  output logic [151:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast,   // message_done
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import cgd_pkg::*;

  logic [15:0] max_dim_q;
  logic [7:0]  max_kind_q;
  logic        room2, step;
  pair_t       pair;
  result_t     res;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = room2;
  assign step = s_axis_tvalid && room2;

  // Writes to any other index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q <= 16'd4096;
      max_kind_q <= 8'd2;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegMaxDim) max_dim_q <= cfg_data_i;
      else if (cfg_index_i == RegMaxKind) max_kind_q <= cfg_data_i[7:0];
    end
  end

  cgd_front u_front (
    .clk_i, .rst_ni, .step_i(step), .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .max_dim_i(max_dim_q), .max_kind_i(max_kind_q), .pair_o(pair)
  );

  cgd_queue u_queue (
    .clk_i, .rst_ni, .pair_i(pair), .room2_o(room2),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.message_done;
  assign m_axis_tdata = {res.status, res.cursor_shown, res.char_value, res.bg_color,
                         res.fg_color, res.glyph_width, res.underline, res.attrs,
                         res.col, res.row};

endmodule
